### hw/rtl/lsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants of the latency spike detector
// Sizes, register map, controller states and the command/status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lsd_pkg;

	// Storage and field sizes.
	localparam int HISTORY_DEPTH = 32;
	localparam int LATENCY_BITS  = 16;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = HIST_AW + 1;
	localparam int FIELD_W       = LATENCY_BITS + 1;

	// Configuration register widths.
	localparam int FACTOR_W = 4;
	localparam int MARGIN_W = 16;
	localparam int WIN_W    = 6;

	// Derived arithmetic widths.
	localparam int CMP_W  = (WIN_W > CNT_W) ? WIN_W : CNT_W;
	localparam int MULT_W = LATENCY_BITS + FACTOR_W;
	localparam int FLAT_W = ((LATENCY_BITS > MARGIN_W) ? LATENCY_BITS : MARGIN_W) + 1;
	localparam int THR_W  = (MULT_W > FLAT_W) ? MULT_W : FLAT_W;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_W   = 2 * FIELD_W;
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 1 + LATENCY_BITS + FIELD_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	// APB register map.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_SPIKE_FACTOR  = 2'd0,
		REG_SPIKE_MARGIN  = 2'd1,
		REG_BASE_WINDOW   = 2'd2,
		REG_MIN_SAMPLES   = 2'd3
	} reg_idx_t;

	localparam logic [FACTOR_W-1:0] FACTOR_RST  = FACTOR_W'(3);
	localparam logic [MARGIN_W-1:0] MARGIN_RST  = MARGIN_W'(150);
	localparam logic [WIN_W-1:0]    WINDOW_RST  = WIN_W'(30);
	localparam logic [WIN_W-1:0]    MIN_SMP_RST = WIN_W'(5);

	// Result kinds.
	localparam logic EV_SPIKE_BEGIN = 1'b0;
	localparam logic EV_SPIKE_END   = 1'b1;

	typedef struct packed {
		logic [FACTOR_W-1:0] spike_factor;
		logic [MARGIN_W-1:0] spike_margin_ms;
		logic [WIN_W-1:0]    baseline_window;
		logic [WIN_W-1:0]    min_baseline_samples;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATHER,
		ST_MEDIAN,
		ST_THRESH,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic pick_median;
		logic calc_thresh;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic more_reads;
		logic blocked;
	} dp_sts_t;

endpackage

### hw/rtl/lsd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_regs: configuration register file
// APB slave holding the four detector settings; always ready.
// ----------------------------------------------------------------------------
module lsd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsd_pkg::APB_AW-1:0]  paddr,
	input  logic [lsd_pkg::APB_DW-1:0]  pwdata,
	output logic [lsd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output lsd_pkg::cfg_t               cfg
);
	import lsd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spike_factor         <= FACTOR_RST;
			cfg_q.spike_margin_ms      <= MARGIN_RST;
			cfg_q.baseline_window      <= WINDOW_RST;
			cfg_q.min_baseline_samples <= MIN_SMP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SPIKE_FACTOR: cfg_q.spike_factor         <= pwdata[FACTOR_W-1:0];
				REG_SPIKE_MARGIN: cfg_q.spike_margin_ms      <= pwdata[MARGIN_W-1:0];
				REG_BASE_WINDOW:  cfg_q.baseline_window      <= pwdata[WIN_W-1:0];
				REG_MIN_SAMPLES:  cfg_q.min_baseline_samples <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SPIKE_FACTOR: prdata = APB_DW'(cfg_q.spike_factor);
			REG_SPIKE_MARGIN: prdata = APB_DW'(cfg_q.spike_margin_ms);
			REG_BASE_WINDOW:  prdata = APB_DW'(cfg_q.baseline_window);
			REG_MIN_SAMPLES:  prdata = APB_DW'(cfg_q.min_baseline_samples);
			default:          prdata = '0;
		endcase
	end

endmodule

### hw/rtl/lsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_ctrl: sequencing controller
// Walks one tick through gather, median pick, threshold and decision.
// ----------------------------------------------------------------------------
module lsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsd_pkg::dp_sts_t  sts,
	output lsd_pkg::dp_cmd_t  cmd
);
	import lsd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_GATHER;
			ST_GATHER: if (!sts.more_reads) state_d = ST_MEDIAN;
			ST_MEDIAN: state_d = ST_THRESH;
			ST_THRESH: state_d = ST_DECIDE;
			ST_DECIDE: if (!sts.blocked) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_GATHER: cmd.issue       = sts.more_reads;
			ST_MEDIAN: cmd.pick_median = 1'b1;
			ST_THRESH: cmd.calc_thresh = 1'b1;
			ST_DECIDE: cmd.commit      = !sts.blocked;
			default: ;
		endcase
	end

endmodule

### hw/rtl/lsd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_dp: detector datapath
// History memory, insertion sorter, threshold math, hysteresis and the
// output register.
// ----------------------------------------------------------------------------
module lsd_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lsd_pkg::cfg_t                      cfg,
	input  lsd_pkg::dp_cmd_t                   cmd,
	output lsd_pkg::dp_sts_t                   sts,
	input  logic [lsd_pkg::FIELD_W-1:0]        proxy_latency_ms,
	input  logic [lsd_pkg::FIELD_W-1:0]        direct_latency_ms,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               event_kind,
	output logic                               direct_also_bad,
	output logic [lsd_pkg::LATENCY_BITS-1:0]   baseline_ms,
	output logic [lsd_pkg::FIELD_W-1:0]        reported_latency_ms
);
	import lsd_pkg::*;

	// History: valid bit above the value.
	logic [FIELD_W-1:0] hist_mem [HISTORY_DEPTH];
	logic [FIELD_W-1:0] rd_data_s1;
	logic               rd_vld_s1;

	logic [HIST_AW-1:0] wp_q;
	logic [CNT_W-1:0]   count_q;
	logic               spike_q;

	// Current tick.
	logic                    plost_q, dlost_q;
	logic [LATENCY_BITS-1:0] pval_q, dval_q;

	logic [CNT_W-1:0]  win_q, k_q, n_q;
	logic [CMP_W-1:0]  bw_x, cnt_x;
	logic [HIST_AW-1:0] rd_addr;

	// Sorted samples.
	logic [LATENCY_BITS-1:0] srt_q [HISTORY_DEPTH];
	logic [LATENCY_BITS-1:0] srt_d [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] gt;
	logic [LATENCY_BITS-1:0] ins_v;

	logic [LATENCY_BITS-1:0] base_q;
	logic [MULT_W-1:0]       mult_q;
	logic [FLAT_W-1:0]       flat_q;
	logic [THR_W-1:0]        thr;
	logic                    detect, bad, ev_begin, ev_end, ev_fire;

	logic                    out_valid_q, kind_q, dbad_q;
	logic [LATENCY_BITS-1:0] obase_q;
	logic [FIELD_W-1:0]      orep_q;

	assign bw_x    = CMP_W'(cfg.baseline_window);
	assign cnt_x   = CMP_W'(count_q);
	assign rd_addr = wp_q - HIST_AW'(1) - k_q[HIST_AW-1:0];

	assign sts.more_reads = (k_q < win_q);

	// Memory: one write at commit, one registered read during gather.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hist_mem[wp_q] <= {!plost_q, pval_q};
		end
		if (cmd.issue) begin
			rd_data_s1 <= hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
		end
	end

	// Insertion into the sorted row: each lane looks at itself and its left neighbor.
	assign ins_v = rd_data_s1[LATENCY_BITS-1:0];

	always_comb begin
		for (int j = 0; j < HISTORY_DEPTH; j++) begin
			gt[j] = (CNT_W'(j) < n_q) && (srt_q[j] > ins_v);
		end
		for (int j = 0; j < HISTORY_DEPTH; j++) begin
			srt_d[j] = srt_q[j];
			if (gt[j] || (CNT_W'(j) == n_q)) begin
				if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
					srt_d[j] = srt_q[(j > 0) ? j - 1 : 0];
				end else begin
					srt_d[j] = ins_v;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_data_s1[LATENCY_BITS]) begin
			srt_q <= srt_d;
		end
		if (cmd.accept) begin
			plost_q <= proxy_latency_ms[LATENCY_BITS];
			dlost_q <= direct_latency_ms[LATENCY_BITS];
			pval_q  <= proxy_latency_ms[LATENCY_BITS-1:0];
			dval_q  <= direct_latency_ms[LATENCY_BITS-1:0];
		end
		if (cmd.pick_median) begin
			base_q <= srt_q[HIST_AW'(n_q >> 1)];
		end
		if (cmd.calc_thresh) begin
			mult_q <= MULT_W'(base_q) * MULT_W'(cfg.spike_factor);
			flat_q <= FLAT_W'(base_q) + FLAT_W'(cfg.spike_margin_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			k_q   <= '0;
			n_q   <= '0;
		end else begin
			if (cmd.accept) begin
				win_q <= CNT_W'((bw_x < cnt_x) ? bw_x : cnt_x);
				k_q   <= '0;
				n_q   <= '0;
			end else begin
				if (cmd.issue) begin
					k_q <= k_q + CNT_W'(1);
				end
				if (rd_vld_s1 && rd_data_s1[LATENCY_BITS]) begin
					n_q <= n_q + CNT_W'(1);
				end
			end
		end
	end

	// Decision.
	assign thr      = (THR_W'(mult_q) > THR_W'(flat_q)) ? THR_W'(mult_q) : THR_W'(flat_q);
	assign detect   = (n_q != '0) && (CMP_W'(n_q) >= CMP_W'(cfg.min_baseline_samples));
	assign bad      = plost_q || (THR_W'(pval_q) > thr);
	assign ev_begin = detect && bad && !spike_q;
	assign ev_end   = detect && !bad && spike_q;
	assign ev_fire  = ev_begin || ev_end;

	assign sts.blocked = ev_fire && out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			count_q     <= '0;
			spike_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && ev_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				wp_q <= wp_q + HIST_AW'(1);
				if (count_q != CNT_W'(HISTORY_DEPTH)) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (ev_begin) begin
					spike_q <= 1'b1;
				end else if (ev_end) begin
					spike_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && ev_fire) begin
			kind_q  <= ev_begin ? EV_SPIKE_BEGIN : EV_SPIKE_END;
			dbad_q  <= ev_begin && (dlost_q || (MULT_W'(dval_q) > mult_q));
			obase_q <= base_q;
			orep_q  <= plost_q ? '1 : {1'b0, pval_q};
		end
	end

	assign out_valid           = out_valid_q;
	assign event_kind          = kind_q;
	assign direct_also_bad     = dbad_q;
	assign baseline_ms         = obase_q;
	assign reported_latency_ms = orep_q;

endmodule

### hw/rtl/latency_spike_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_spike_detector_core: median-baseline latency spike detector
// Flags the start and end of proxy latency spikes against the running median
// of recent samples.
// ----------------------------------------------------------------------------
// Each input transaction on the s_axis channel is one probe tick carrying a
// proxy-path and a direct-path latency (negative means no reply). A result
// transaction on the m_axis channel appears only when a spike begins or ends;
// most ticks produce none.
// Settings are written through the APB port; the user must do so only while
// the block is idle, which the block itself does not enforce. pready is
// always high and reads return the stored values. A tick is taken only once
// the last one has passed gather, median pick, threshold and decision. Gather
// reads win stored samples, win being the effective baseline window (at most
// the stored tick count and 32), through the single read port of the history
// memory, which feeds one stored sample per cycle into the insertion sorter.
// A result is held in an output register; the block keeps accepting ticks
// while it waits. If the receiver stalls and a second result is due, the
// block holds in its decision step until the first one is taken.
// Reset empties the history, clears the spike flag and restores the settings
// to factor 3, margin 150 ms, window 30 and minimum sample count 5.
// ----------------------------------------------------------------------------
module latency_spike_detector_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lsd_pkg::APB_AW-1:0]   paddr,
	input  logic [lsd_pkg::APB_DW-1:0]   pwdata,
	output logic [lsd_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	// Tick input.
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [16:0] proxy_latency_ms, [33:17] direct_latency_ms, zero padded
	input  logic [lsd_pkg::IN_TW-1:0]    s_axis_tdata,
	// Event output.
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [0] direct_also_bad, [16:1] baseline_ms, [33:17] reported_latency_ms, zero padded
	output logic [lsd_pkg::OUT_TW-1:0]   m_axis_tdata,
	// [0] event_kind
	output logic                         m_axis_tuser
);
	import lsd_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	logic                    direct_also_bad;
	logic [LATENCY_BITS-1:0] baseline_ms;
	logic [FIELD_W-1:0]      reported_latency_ms;

	lsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller sequences one tick at a time; it accepts only when idle.
	lsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsd_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg),
		.cmd                 (cmd),
		.sts                 (sts),
		.proxy_latency_ms    (s_axis_tdata[FIELD_W-1:0]),
		.direct_latency_ms   (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
		.out_valid           (m_axis_tvalid),
		.out_ready           (m_axis_tready),
		.event_kind          (m_axis_tuser),
		.direct_also_bad     (direct_also_bad),
		.baseline_ms         (baseline_ms),
		.reported_latency_ms (reported_latency_ms)
	);

	// Pack the result fields, lowest field first, zero padded to whole bytes.
	assign m_axis_tdata = OUT_TW'({reported_latency_ms, baseline_ms, direct_also_bad});

endmodule

### hw/rtl/lsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_checker: port-level assertions
// Watches the top-level ports of the spike detector over time.
// ----------------------------------------------------------------------------
module lsd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pready,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [lsd_pkg::OUT_TW-1:0]  m_axis_tdata,
	input logic                        m_axis_tuser
);
	import lsd_pkg::*;

	// One tick is worked at a time: the input closes after each transaction.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	// A result never rises straight after a tick is accepted: the tick must first pass the later steps.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared right after a tick was accepted");

	// An end-of-spike result never carries a direct-path verdict.
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == EV_SPIKE_END) |-> !m_axis_tdata[0])
		else $error("end-of-spike result with direct_also_bad set");

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind latency_spike_detector_core lsd_checker u_lsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pready        (pready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the latency spike detector core
// Streams probe ticks into the core under several register settings, predicts
// the spike begin and end events from its own copy of the history and flags,
// and compares every event transaction field by field with the prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import lsd_pkg::*;

	// One probe tick as it travels on the input stream.
	typedef struct packed {
		logic [FIELD_W-1:0] direct;
		logic [FIELD_W-1:0] proxy;
	} probe_tick_t;

	// One predicted spike event.
	typedef struct {
		logic                    kind;
		logic                    direct_bad;
		logic [LATENCY_BITS-1:0] baseline;
		logic [FIELD_W-1:0]      reported;
	} spike_event_t;

	localparam logic [FIELD_W-1:0] LOST_MS = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	// [16:0] proxy_latency_ms, [33:17] direct_latency_ms, zero padded
	logic [IN_TW-1:0]   s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	// [0] direct_also_bad, [16:1] baseline_ms, [33:17] reported_latency_ms, zero padded
	logic [OUT_TW-1:0]  m_axis_tdata;
	// [0] event_kind
	logic               m_axis_tuser;

	latency_spike_detector_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Bench copy of the settings, updated on every register write.
	logic [FACTOR_W-1:0]     set_factor = FACTOR_RST;
	logic [MARGIN_W-1:0]     set_margin = MARGIN_RST;
	logic [WIN_W-1:0]        set_window = WINDOW_RST;
	logic [WIN_W-1:0]        set_min_samples = MIN_SMP_RST;

	// Bench copy of the detector state.
	logic [LATENCY_BITS-1:0] past_ms [HISTORY_DEPTH];
	bit                      past_ok [HISTORY_DEPTH];
	int                      past_fill = 0;
	logic [HIST_AW-1:0]      past_wr = '0;
	bit                      in_spike = 1'b0;

	probe_tick_t   tick_backlog[$];
	spike_event_t  due_events[$];
	int            ticks_taken;
	int            error_count = 0;
	int            tx_wait;
	int            rx_wait;
	int            hold_left;
	bit            hold_armed;
	bit            calm = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	function automatic int clamp_ms(input int v);
		if (v < 0)
			return 0;
		if (v > 65535)
			return 65535;
		return v;
	endfunction

	// Works out what one accepted tick does to the bench state and whether it
	// raises an event. The event, if any, goes to the back of due_events.
	function automatic void judge_tick(input probe_tick_t t);
		int           sorted [HISTORY_DEPTH];
		int           n;
		int           span;
		int           j;
		int           v;
		int           baseline;
		int           mult;
		int           flat;
		int           thr;
		bit           proxy_lost;
		bit           bad;
		logic [HIST_AW-1:0] slot;
		spike_event_t ev;

		proxy_lost = t.proxy[FIELD_W-1];
		n = 0;
		span = set_window;
		if (span > HISTORY_DEPTH)
			span = HISTORY_DEPTH;
		if (span > past_fill)
			span = past_fill;

		// Gather the valid samples of the window, newest first, kept in order.
		for (int k = 0; k < span; k++) begin
			slot = past_wr - HIST_AW'(k + 1);
			if (past_ok[slot]) begin
				v = past_ms[slot];
				j = n;
				while (j > 0 && sorted[j-1] > v) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = v;
				n++;
			end
		end

		if (n > 0 && n >= set_min_samples) begin
			baseline = sorted[n/2];
			mult = baseline * set_factor;
			flat = baseline + set_margin;
			thr = (mult > flat) ? mult : flat;
			bad = proxy_lost || (int'(t.proxy[LATENCY_BITS-1:0]) > thr);
			ev.baseline = baseline[LATENCY_BITS-1:0];
			ev.reported = proxy_lost ? LOST_MS : {1'b0, t.proxy[LATENCY_BITS-1:0]};
			if (bad && !in_spike) begin
				in_spike = 1'b1;
				ev.kind = EV_SPIKE_BEGIN;
				ev.direct_bad = t.direct[FIELD_W-1] ||
					(int'(t.direct[LATENCY_BITS-1:0]) > mult);
				due_events.push_back(ev);
			end else if (!bad && in_spike) begin
				in_spike = 1'b0;
				ev.kind = EV_SPIKE_END;
				ev.direct_bad = 1'b0;
				due_events.push_back(ev);
			end
		end

		// The tick enters the history only after the decision.
		past_ms[past_wr] = t.proxy[LATENCY_BITS-1:0];
		past_ok[past_wr] = !proxy_lost;
		past_wr = past_wr + 1'b1;
		if (past_fill < HISTORY_DEPTH)
			past_fill++;
	endfunction

	// Sender: presents the backlog one tick at a time with random gaps.
	always @(posedge clk or negedge arst_n) begin : sender
		int gap;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			tx_wait <= 0;
			ticks_taken <= 0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			judge_tick(s_axis_tdata[IN_W-1:0]);
			ticks_taken <= ticks_taken + 1;
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap == 0 && tick_backlog.size() != 0) begin
				s_axis_tdata <= IN_TW'(tick_backlog.pop_front());
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
				tx_wait <= gap;
			end
		end else if (!s_axis_tvalid) begin
			if (tx_wait != 0) begin
				tx_wait <= tx_wait - 1;
			end else if (tick_backlog.size() != 0) begin
				s_axis_tdata <= IN_TW'(tick_backlog.pop_front());
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// Receiver: checks each event transaction against the oldest prediction,
	// then stalls at random, except in calm phases.
	always @(posedge clk or negedge arst_n) begin : receiver
		int nxt;
		spike_event_t ev;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			nxt = rx_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_events.size() == 0) begin
					flag_error($sformatf("unexpected event kind %0b baseline %0d",
						m_axis_tuser, m_axis_tdata[16:1]));
				end else begin
					ev = due_events.pop_front();
					if (m_axis_tuser !== ev.kind)
						flag_error($sformatf("event_kind %0b, want %0b",
							m_axis_tuser, ev.kind));
					if (m_axis_tdata[0] !== ev.direct_bad)
						flag_error($sformatf("direct_also_bad %0b, want %0b",
							m_axis_tdata[0], ev.direct_bad));
					if (m_axis_tdata[16:1] !== ev.baseline)
						flag_error($sformatf("baseline_ms %0d, want %0d",
							m_axis_tdata[16:1], ev.baseline));
					if (m_axis_tdata[33:17] !== ev.reported)
						flag_error($sformatf("reported_latency_ms %h, want %h",
							m_axis_tdata[33:17], ev.reported));
				end
				nxt = calm ? 0 : $urandom_range(0, 3);
			end else if (nxt != 0) begin
				nxt = nxt - 1;
			end
			rx_wait <= nxt;
			m_axis_tready <= (nxt == 0) && (hold_left == 0);
		end
	end

	// Long receiver hold-off once, early in the run, so that the output
	// register fills and the core has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_armed <= 1'b1;
		end else if (hold_armed && ticks_taken == 120) begin
			hold_left <= 400;
			hold_armed <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic push_tick(input int proxy, input int direct);
		probe_tick_t t;
		t.proxy = FIELD_W'(proxy);
		t.direct = FIELD_W'(direct);
		tick_backlog.push_back(t);
	endtask

	// Waits until every tick is taken and every event has arrived, then lets
	// the core finish a tick that raises no event.
	task automatic wait_drained();
		@(negedge clk);
		while (tick_backlog.size() != 0 || s_axis_tvalid || due_events.size() != 0)
			@(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_SPIKE_FACTOR: set_factor = value[FACTOR_W-1:0];
			REG_SPIKE_MARGIN: set_margin = value[MARGIN_W-1:0];
			REG_BASE_WINDOW:  set_window = value[WIN_W-1:0];
			REG_MIN_SAMPLES:  set_min_samples = value[WIN_W-1:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// A random latency: mostly close to the typical level, sometimes a spike,
	// a lost probe or any value of the field at all.
	function automatic int draw_latency(input int typical, input int spike_pct,
			input int lost_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < spike_pct)
			return clamp_ms(typical * int'($urandom_range(2, 16)) +
				int'($urandom_range(1, 400)));
		if (r < spike_pct + lost_pct)
			return ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 65536)) : -1;
		if (r < spike_pct + lost_pct + 5)
			return int'($urandom_range(0, 65535));
		return clamp_ms(typical - typical / 8 + int'($urandom_range(0, typical / 4 + 8)));
	endfunction

	task automatic run_phase(input int factor, input int margin, input int window,
			input int min_samples, input int typical, input bit no_idle, input int count);
		wait_drained();
		write_reg(REG_SPIKE_FACTOR, factor);
		write_reg(REG_SPIKE_MARGIN, margin);
		write_reg(REG_BASE_WINDOW, window);
		write_reg(REG_MIN_SAMPLES, min_samples);
		@(negedge clk);
		calm = no_idle;
		for (int i = 0; i < count; i++)
			push_tick(draw_latency(typical, 14, 8), draw_latency(typical, 25, 15));
	endtask

	initial begin
		int window;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks under the reset settings. The first ones have too
		// few valid samples to detect anything, lost probes included.
		@(negedge clk);
		push_tick(100, 100);
		push_tick(0, 0);
		push_tick(100, -1);
		push_tick(120, 65535);
		push_tick(-1, 50);
		push_tick(110, 90);
		push_tick(105, 100);
		// Spike with the direct path also over the threshold, then recovery.
		push_tick(500, 400);
		push_tick(600, 50);
		push_tick(100, 0);
		// Lost proxy starts a spike; the end event carries no direct verdict.
		push_tick(-1, -1);
		push_tick(100, 65535);
		push_tick(65535, 10);
		push_tick(0, 0);
		// Negative values other than -1 count as lost too.
		push_tick(-65536, -65531);
		push_tick(-2, 200);
		push_tick(90, 0);
		push_tick(65535, 65535);
		push_tick(100, 100);
		push_tick(300, 300);

		// Smallest settings: every rise over the previous tick is a spike.
		run_phase(1, 0, 1, 1, 200, 1'b0, 210);
		// Largest settings: only lost probes can exceed the threshold.
		run_phase(15, 65535, 32, 32, 60, 1'b0, 210);
		run_phase(2, 20, 8, 3, 1500, 1'b1, 210);
		run_phase(4, 300, 16, 8, 20000, 1'b0, 210);
		for (int p = 0; p < 4; p++) begin
			window = $urandom_range(1, 32);
			run_phase($urandom_range(1, 15),
				($urandom_range(0, 1) == 0) ? $urandom_range(0, 500) : $urandom_range(0, 65535),
				window, $urandom_range(1, window), $urandom_range(5, 3000),
				p[0], 210);
		end

		wait_drained();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit, several times the slowest correct run.
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
